>>> rtl/core/spoi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sub-pixel offset interpolator package
// Sizes, codes and the types shared by the pipeline stages.
// ----------------------------------------------------------------------------
package spoi_pkg;

  localparam int NUM_GRADES = 256;
  localparam int MAX_POINTS = 16;
  localparam int NUM_CHIPS  = 10;
  localparam int NUM_SETS   = 2;

  localparam int ROWS    = NUM_SETS * NUM_GRADES;
  localparam int ROW_AW  = $clog2(ROWS);
  localparam int CLR_W   = ROW_AW + 1;
  localparam int IDX_W   = $clog2(MAX_POINTS);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int MASK_W  = NUM_CHIPS;
  localparam logic [MASK_W-1:0] MASK_RESET = MASK_W'(160);

  localparam int OP_W    = 2;
  localparam int CHIP_W  = 4;
  localparam int GRADE_W = 8;
  localparam int PIDX_W  = 4;
  localparam int PCNT_W  = 5;
  localparam int E_W     = 16;
  localparam int OFS_W   = 16;
  localparam int ST_W    = 2;

  localparam int DIFF_W  = E_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int DVD_W   = PROD_W;
  localparam int DVS_W   = DIFF_W;
  localparam int QS_W    = DVD_W + 1;
  localparam int SUM_W   = QS_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_QUERY = 2'd0,
    OP_POINT = 2'd1,
    OP_COUNT = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOTABLE = 2'd1,
    ST_WRITTEN = 2'd2,
    ST_SAT     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_NOTABLE,
    KIND_EQUAL,
    KIND_INTERP
  } kind_e;

  typedef logic [MAX_POINTS-1:0][E_W-1:0]   e_row_t;
  typedef logic [MAX_POINTS-1:0][OFS_W-1:0] o_row_t;

  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic [E_W-1:0]   energy;
    logic [CNT_W-1:0] n;
    e_row_t           e_row;
    o_row_t           x_row;
    o_row_t           y_row;
  } tbl_out_t;

  typedef struct packed {
    kind_e                    kind;
    logic signed [OFS_W-1:0]  xi;
    logic signed [OFS_W-1:0]  yi;
    logic                     sx;
    logic                     sy;
  } div_side_t;

  typedef struct packed {
    logic             valid;
    logic [DVD_W-1:0] dvd_x;
    logic [DVD_W-1:0] dvd_y;
    logic [DVS_W-1:0] dvs;
    div_side_t        side;
  } div_in_t;

  typedef struct packed {
    logic             valid;
    logic [DVD_W-1:0] q_x;
    logic [DVD_W-1:0] q_y;
    div_side_t        side;
  } div_out_t;

  function automatic logic [DVS_W+DVD_W-1:0] div_step(
    input logic [DVS_W-1:0] rem,
    input logic [DVD_W-1:0] dq,
    input logic [DVS_W-1:0] dvs
  );
    logic [DVS_W:0]   t;
    logic             ge;
    logic [DVS_W:0]   nr;
    t  = {rem, dq[DVD_W-1]};
    ge = (t >= {1'b0, dvs});
    nr = ge ? (t - {1'b0, dvs}) : t;
    return {nr[DVS_W-1:0], dq[DVD_W-2:0], ge};
  endfunction

endpackage

>>> rtl/core/subpixel_offset_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sub-pixel offset interpolator
// Piecewise linear table interpolation of x and y offsets over energy.
// ----------------------------------------------------------------------------
// After reset the block clears its point-count store, one entry a cycle, and
// holds busy_o high until all 512 entries are clear; after that busy_o stays
// low and an item is taken in every cycle that start_i is high. Every item,
// query or write, gives exactly one result on done_o, in order, after passing
// one table read stage, four search and slope stages, a 34-stage divider
// (one quotient bit per stage) and two stages that apply the sign, add and saturate.
// Results cannot be held off. A write is seen by every item taken after it.
// The mask register may be written at any time.
// ----------------------------------------------------------------------------
module subpixel_offset_interpolator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                cfg_we_i,
  input  logic [spoi_pkg::MASK_W-1:0]         cfg_wdata_i,
  input  logic [spoi_pkg::OP_W-1:0]           operation_i,
  input  logic [spoi_pkg::CHIP_W-1:0]         chip_i,
  input  logic                                table_set_i,
  input  logic [spoi_pkg::GRADE_W-1:0]        grade_i,
  input  logic [spoi_pkg::PIDX_W-1:0]         point_index_i,
  input  logic [spoi_pkg::E_W-1:0]            energy_i,
  input  logic signed [spoi_pkg::OFS_W-1:0]   x_offset_i,
  input  logic signed [spoi_pkg::OFS_W-1:0]   y_offset_i,
  input  logic [spoi_pkg::PCNT_W-1:0]         point_count_i,
  output logic                                done_o,
  output logic signed [spoi_pkg::OFS_W-1:0]   x_shift_o,
  output logic signed [spoi_pkg::OFS_W-1:0]   y_shift_o,
  output logic [spoi_pkg::ST_W-1:0]           status_o
);
  import spoi_pkg::*;

  logic [MASK_W-1:0] mask_q;
  logic              clearing;
  logic              accept;
  tbl_out_t          tbl;
  div_in_t           dvi;
  div_out_t          dvo;

  assign busy_o = clearing;
  assign accept = start_i & ~clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= MASK_RESET;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i;
    end
  end

  spoi_tables u_tables (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .mask_i        (mask_q),
    .operation_i   (operation_i),
    .chip_i        (chip_i),
    .table_set_i   (table_set_i),
    .grade_i       (grade_i),
    .point_index_i (point_index_i),
    .energy_i      (energy_i),
    .x_offset_i    (x_offset_i),
    .y_offset_i    (y_offset_i),
    .point_count_i (point_count_i),
    .clearing_o    (clearing),
    .out_o         (tbl)
  );

  spoi_search u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tbl),
    .out_o  (dvi)
  );

  spoi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (dvi),
    .out_o  (dvo)
  );

  // apply sign
  logic                    v5_q;
  div_side_t               s5_q;
  logic signed [QS_W-1:0]  qsx5_q, qsy5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= dvo.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_q   <= dvo.side;
    qsx5_q <= dvo.side.sx ? -$signed({1'b0, dvo.q_x}) : $signed({1'b0, dvo.q_x});
    qsy5_q <= dvo.side.sy ? -$signed({1'b0, dvo.q_y}) : $signed({1'b0, dvo.q_y});
  end

  // add, saturate, output
  localparam logic signed [SUM_W-1:0] OFS_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] OFS_MIN = -SUM_W'(32768);

  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic                    sat_x, sat_y;
  logic signed [OFS_W-1:0] cx, cy;
  logic signed [OFS_W-1:0] x_d, y_d;
  status_e                 st_d;
  logic                    done_q;
  logic signed [OFS_W-1:0] x_q, y_q;
  status_e                 st_q;

  assign sum_x = SUM_W'(s5_q.xi) + SUM_W'(qsx5_q);
  assign sum_y = SUM_W'(s5_q.yi) + SUM_W'(qsy5_q);

  always_comb begin
    sat_x = 1'b1;
    sat_y = 1'b1;
    priority if (sum_x > OFS_MAX) begin
      cx = OFS_MAX[OFS_W-1:0];
    end else if (sum_x < OFS_MIN) begin
      cx = OFS_MIN[OFS_W-1:0];
    end else begin
      cx    = sum_x[OFS_W-1:0];
      sat_x = 1'b0;
    end
    priority if (sum_y > OFS_MAX) begin
      cy = OFS_MAX[OFS_W-1:0];
    end else if (sum_y < OFS_MIN) begin
      cy = OFS_MIN[OFS_W-1:0];
    end else begin
      cy    = sum_y[OFS_W-1:0];
      sat_y = 1'b0;
    end
  end

  always_comb begin
    unique case (s5_q.kind)
      KIND_INTERP: begin
        x_d  = cx;
        y_d  = cy;
        st_d = (sat_x | sat_y) ? ST_SAT : ST_OK;
      end
      KIND_EQUAL: begin
        x_d  = s5_q.xi;
        y_d  = s5_q.yi;
        st_d = ST_OK;
      end
      KIND_NOTABLE: begin
        x_d  = '0;
        y_d  = '0;
        st_d = ST_NOTABLE;
      end
      default: begin
        x_d  = '0;
        y_d  = '0;
        st_d = ST_WRITTEN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    y_q  <= y_d;
    st_q <= st_d;
  end

  assign done_o    = done_q;
  assign x_shift_o = x_q;
  assign y_shift_o = y_q;
  assign status_o  = st_q;

endmodule

>>> rtl/core/spoi_tables.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sub-pixel offset interpolator table store
// Point and count memories, count clearing sweep and the read stage.
// ----------------------------------------------------------------------------
module spoi_tables (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [spoi_pkg::MASK_W-1:0]   mask_i,
  input  logic [spoi_pkg::OP_W-1:0]     operation_i,
  input  logic [spoi_pkg::CHIP_W-1:0]   chip_i,
  input  logic                          table_set_i,
  input  logic [spoi_pkg::GRADE_W-1:0]  grade_i,
  input  logic [spoi_pkg::PIDX_W-1:0]   point_index_i,
  input  logic [spoi_pkg::E_W-1:0]      energy_i,
  input  logic [spoi_pkg::OFS_W-1:0]    x_offset_i,
  input  logic [spoi_pkg::OFS_W-1:0]    y_offset_i,
  input  logic [spoi_pkg::PCNT_W-1:0]   point_count_i,
  output logic                          clearing_o,
  output spoi_pkg::tbl_out_t            out_o
);
  import spoi_pkg::*;

  e_row_t            e_mem [ROWS];
  o_row_t            x_mem [ROWS];
  o_row_t            y_mem [ROWS];
  logic [CNT_W-1:0]  c_mem [ROWS];

  logic [CLR_W-1:0]  clr_q, clr_d;
  logic              clearing;
  logic [MASK_W-1:0] mask_sh;
  logic              qset;
  logic              grade_ok;
  logic              pidx_ok;
  logic [ROW_AW-1:0] wr_row, rd_row;
  logic [IDX_W-1:0]  col;
  logic [CNT_W-1:0]  cnt_clip;
  op_e               op;
  kind_e             kind_d;
  logic              valid_q;
  kind_e             kind_q;
  logic [E_W-1:0]    energy_q;
  logic [CNT_W-1:0]  n_q;
  e_row_t            e_row_q;
  o_row_t            x_row_q, y_row_q;

  assign op       = op_e'(operation_i);
  assign clearing = (clr_q < CLR_W'(ROWS));
  assign clr_d    = clearing ? clr_q + 1'b1 : clr_q;
  assign mask_sh  = mask_i >> chip_i;
  assign qset     = (32'(chip_i) < NUM_CHIPS) & mask_sh[0];
  assign grade_ok = (32'(grade_i) < NUM_GRADES);
  assign pidx_ok  = (32'(point_index_i) < MAX_POINTS);
  assign wr_row   = ROW_AW'(ROW_AW'(table_set_i) * ROW_AW'(NUM_GRADES) + ROW_AW'(grade_i));
  assign rd_row   = ROW_AW'(ROW_AW'(qset) * ROW_AW'(NUM_GRADES) + ROW_AW'(grade_i));
  assign col      = IDX_W'(point_index_i);
  assign cnt_clip = (32'(point_count_i) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                      : CNT_W'(point_count_i);

  always_comb begin
    unique case (op)
      OP_QUERY: kind_d = grade_ok ? KIND_INTERP : KIND_NOTABLE;
      default:  kind_d = KIND_WRITE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      clr_q   <= clr_d;
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && op == OP_POINT && grade_ok && pidx_ok) begin
      e_mem[wr_row][col] <= energy_i;
      x_mem[wr_row][col] <= x_offset_i;
      y_mem[wr_row][col] <= y_offset_i;
    end
    e_row_q <= e_mem[rd_row];
    x_row_q <= x_mem[rd_row];
    y_row_q <= y_mem[rd_row];
  end

  always_ff @(posedge clk_i) begin
    if (clearing) begin
      c_mem[clr_q[ROW_AW-1:0]] <= '0;
    end else if (accept_i && op == OP_COUNT && grade_ok) begin
      c_mem[wr_row] <= cnt_clip;
    end
    n_q <= c_mem[rd_row];
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    energy_q <= energy_i;
  end

  assign clearing_o   = clearing;
  assign out_o.valid  = valid_q;
  assign out_o.kind   = kind_q;
  assign out_o.energy = energy_q;
  assign out_o.n      = n_q;
  assign out_o.e_row  = e_row_q;
  assign out_o.x_row  = x_row_q;
  assign out_o.y_row  = y_row_q;

endmodule

>>> rtl/core/spoi_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sub-pixel offset interpolator search and slope stages
// Bracketing pair search, differences, products and divider operands.
// ----------------------------------------------------------------------------
module spoi_search (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spoi_pkg::tbl_out_t  in_i,
  output spoi_pkg::div_in_t   out_o
);
  import spoi_pkg::*;

  // search
  logic [IDX_W-1:0]  idx;
  logic              last;
  logic              v1_q;
  kind_e             k1_q;
  logic [E_W-1:0]    e1_q;
  logic [IDX_W-1:0]  lo_q, hi_q;
  e_row_t            er1_q;
  o_row_t            xr1_q, yr1_q;

  always_comb begin
    idx = '0;
    for (int k = 1; k < MAX_POINTS; k++) begin
      if ((k < int'(in_i.n)) && (in_i.e_row[k] <= in_i.energy)) begin
        idx = IDX_W'(k);
      end
    end
    last = ((CNT_W'(idx) + 1'b1) == in_i.n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    k1_q  <= (in_i.kind == KIND_INTERP && in_i.n < CNT_W'(2)) ? KIND_NOTABLE : in_i.kind;
    e1_q  <= in_i.energy;
    lo_q  <= last ? idx - 1'b1 : idx;
    hi_q  <= last ? idx : idx + 1'b1;
    er1_q <= in_i.e_row;
    xr1_q <= in_i.x_row;
    yr1_q <= in_i.y_row;
  end

  // select pair, differences
  logic                     v2_q;
  kind_e                    k2_q;
  logic signed [DIFF_W-1:0] den2_q, de2_q, dx2_q, dy2_q;
  logic signed [OFS_W-1:0]  xi2_q, yi2_q;
  logic [E_W-1:0]           ei, ej;
  logic [OFS_W-1:0]         xi, xj, yi, yj;

  assign ei = er1_q[lo_q];
  assign ej = er1_q[hi_q];
  assign xi = xr1_q[lo_q];
  assign xj = xr1_q[hi_q];
  assign yi = yr1_q[lo_q];
  assign yj = yr1_q[hi_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    k2_q   <= k1_q;
    den2_q <= $signed({1'b0, ej}) - $signed({1'b0, ei});
    de2_q  <= $signed({1'b0, e1_q}) - $signed({1'b0, ei});
    dx2_q  <= $signed({xj[OFS_W-1], xj}) - $signed({xi[OFS_W-1], xi});
    dy2_q  <= $signed({yj[OFS_W-1], yj}) - $signed({yi[OFS_W-1], yi});
    xi2_q  <= $signed(xi);
    yi2_q  <= $signed(yi);
  end

  // products
  logic                     v3_q;
  kind_e                    k3_q;
  logic signed [PROD_W-1:0] px3_q, py3_q;
  logic signed [DIFF_W-1:0] den3_q;
  logic signed [OFS_W-1:0]  xi3_q, yi3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    k3_q   <= k2_q;
    px3_q  <= de2_q * dx2_q;
    py3_q  <= de2_q * dy2_q;
    den3_q <= den2_q;
    xi3_q  <= xi2_q;
    yi3_q  <= yi2_q;
  end

  // divider operands: magnitude of 2*num + den over 2*den
  logic [PROD_W-1:0] ax, ay;
  logic [DIFF_W-1:0] ad;
  logic              v4_q;
  div_in_t           o4_q;
  kind_e             k4;

  assign ax = px3_q[PROD_W-1] ? PROD_W'(-px3_q) : PROD_W'(px3_q);
  assign ay = py3_q[PROD_W-1] ? PROD_W'(-py3_q) : PROD_W'(py3_q);
  assign ad = den3_q[DIFF_W-1] ? DIFF_W'(-den3_q) : DIFF_W'(den3_q);
  assign k4 = (k3_q == KIND_INTERP && den3_q == '0) ? KIND_EQUAL : k3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    o4_q.valid   <= 1'b0;
    o4_q.dvd_x   <= DVD_W'({ax[PROD_W-2:0], 1'b0}) + DVD_W'(ad);
    o4_q.dvd_y   <= DVD_W'({ay[PROD_W-2:0], 1'b0}) + DVD_W'(ad);
    o4_q.dvs     <= {ad[DIFF_W-2:0], 1'b0};
    o4_q.side.kind <= k4;
    o4_q.side.xi <= xi3_q;
    o4_q.side.yi <= yi3_q;
    o4_q.side.sx <= px3_q[PROD_W-1] ^ den3_q[DIFF_W-1];
    o4_q.side.sy <= py3_q[PROD_W-1] ^ den3_q[DIFF_W-1];
  end

  always_comb begin
    out_o       = o4_q;
    out_o.valid = v4_q;
  end

endmodule

>>> rtl/core/spoi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sub-pixel offset interpolator divider
// Restoring divider, one quotient bit per stage, two lanes sharing a divisor.
// ----------------------------------------------------------------------------
module spoi_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spoi_pkg::div_in_t  in_i,
  output spoi_pkg::div_out_t out_o
);
  import spoi_pkg::*;

  localparam int NST = DVD_W;

  logic [NST:0]     vld;
  logic [DVS_W-1:0] rx  [NST+1];
  logic [DVS_W-1:0] ry  [NST+1];
  logic [DVD_W-1:0] qx  [NST+1];
  logic [DVD_W-1:0] qy  [NST+1];
  logic [DVS_W-1:0] dvs [NST+1];
  div_side_t        sd  [NST+1];

  assign vld[0] = in_i.valid;
  assign rx[0]  = '0;
  assign ry[0]  = '0;
  assign qx[0]  = in_i.dvd_x;
  assign qy[0]  = in_i.dvd_y;
  assign dvs[0] = in_i.dvs;
  assign sd[0]  = in_i.side;

  for (genvar s = 0; s < NST; s++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      {rx[s+1], qx[s+1]} <= div_step(rx[s], qx[s], dvs[s]);
      {ry[s+1], qy[s+1]} <= div_step(ry[s], qy[s], dvs[s]);
      dvs[s+1]           <= dvs[s];
      sd[s+1]            <= sd[s];
    end
  end

  assign out_o.valid = vld[NST];
  assign out_o.q_x   = qx[NST];
  assign out_o.q_y   = qy[NST];
  assign out_o.side  = sd[NST];

endmodule
